>>> rtl/hlae_pkg.sv
// ----------------------------------------------------------------------------
// hlae_pkg
// Shared types, character constants and helper functions for the HTML link
// attribute extractor.
// ----------------------------------------------------------------------------
package hlae_pkg;

    localparam int MAX_TAG_BYTES_DEF = 8 * 1024;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [39:0] NAME_A     = 40'h00_0000_0041;
    localparam logic [39:0] NAME_BASE  = 40'h00_4241_5345;
    localparam logic [39:0] NAME_AREA  = 40'h00_4152_4541;
    localparam logic [39:0] NAME_FRAME = 40'h46_5241_4D45;

    localparam logic [2:0] NAME_LEN_MAX = 3'd6;

    typedef enum logic [1:0] {
        ITEM_VALUE    = 2'd0,
        ITEM_COMPLETE = 2'd1,
        ITEM_ABANDON  = 2'd2
    } item_code_t;

    typedef enum logic [1:0] {
        KIND_ANCHOR = 2'd0,
        KIND_BASE   = 2'd1,
        KIND_AREA   = 2'd2,
        KIND_FRAME  = 2'd3
    } kind_t;

    typedef enum logic [9:0] {
        PH_OUTSIDE    = 10'b00_0000_0001,
        PH_AFTER_LT   = 10'b00_0000_0010,
        PH_NAME       = 10'b00_0000_0100,
        PH_KEYWORD    = 10'b00_0000_1000,
        PH_SEEK_EQ    = 10'b00_0001_0000,
        PH_SKIP_WS    = 10'b00_0010_0000,
        PH_QUOTE_OPEN = 10'b00_0100_0000,
        PH_VALUE      = 10'b00_1000_0000,
        PH_DONE       = 10'b01_0000_0000,
        PH_IGNORE     = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic       valid;
        item_code_t code;
        kind_t      kind;
        logic [7:0] data;
    } hlae_res_t;

    typedef struct packed {
        logic       hit;
        kind_t      kind;
    } name_match_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] prog;
    } kw_step_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61) ? c - 8'd32 : c;
    endfunction

    // keyword letter at a position: "href" or "src"
    function automatic logic [7:0] kw_char(input kind_t kind, input logic [1:0] pos);
        logic [7:0] ch;
        if (kind == KIND_FRAME) begin
            unique case (pos)
                2'd0:    ch = 8'h73;
                2'd1:    ch = 8'h72;
                2'd2:    ch = 8'h63;
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (pos)
                2'd0:    ch = 8'h68;
                2'd1:    ch = 8'h72;
                2'd2:    ch = 8'h65;
                default: ch = 8'h66;
            endcase
        end
        return ch;
    endfunction

    function automatic kw_step_t kw_advance(input kind_t kind, input logic [2:0] prog,
                                           input logic [7:0] lc);
        kw_step_t   r;
        logic [2:0] p;
        logic [2:0] len;
        len = (kind == KIND_FRAME) ? 3'd3 : 3'd4;
        if (lc == kw_char(kind, prog[1:0])) begin
            p = prog + 3'd1;
        end else begin
            p = (lc == kw_char(kind, 2'd0)) ? 3'd1 : 3'd0;
        end
        r.hit  = (p >= len);
        r.prog = r.hit ? 3'd0 : p;
        return r;
    endfunction

    function automatic name_match_t match_name(input logic [39:0] chars,
                                               input logic [2:0] len);
        name_match_t m;
        m.hit  = 1'b1;
        m.kind = KIND_ANCHOR;
        if ((len == 3'd1) && (chars == NAME_A)) begin
            m.kind = KIND_ANCHOR;
        end else if ((len == 3'd4) && (chars == NAME_BASE)) begin
            m.kind = KIND_BASE;
        end else if ((len == 3'd4) && (chars == NAME_AREA)) begin
            m.kind = KIND_AREA;
        end else if ((len == 3'd5) && (chars == NAME_FRAME)) begin
            m.kind = KIND_FRAME;
        end else begin
            m.hit = 1'b0;
        end
        return m;
    endfunction

endpackage

>>> rtl/hlae_scan.sv
// ----------------------------------------------------------------------------
// hlae_scan
// Tag scanner: holds the per-tag state and turns one document byte into at
// most one result per accepted request.
// ----------------------------------------------------------------------------
module hlae_scan
    import hlae_pkg::*;
#(
    parameter int MAX_TAG_BYTES = MAX_TAG_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output hlae_res_t  res
);

    localparam int TAG_LEN_W = $clog2(MAX_TAG_BYTES + 1);
    localparam logic [TAG_LEN_W-1:0] TAG_LEN_MAX = TAG_LEN_W'(MAX_TAG_BYTES);

    phase_t                phase_reg, phase_next;
    logic [TAG_LEN_W-1:0]  tag_len_reg, tag_len_next;
    logic [39:0]           name_chars_reg, name_chars_next;
    logic [2:0]            name_len_reg, name_len_next;
    kind_t                 kind_reg, kind_next;
    logic [2:0]            prog_reg, prog_next;
    logic                  started_reg, started_next;

    always_comb
    begin
        logic [7:0]  lc;
        kw_step_t    kw_cur;
        kw_step_t    kw_first;
        name_match_t nm;

        lc       = to_lower(data_byte);
        kw_cur   = kw_advance(kind_reg, prog_reg, lc);
        nm       = match_name(name_chars_reg, name_len_reg);
        kw_first = kw_advance(nm.kind, 3'd0, lc);

        phase_next      = phase_reg;
        tag_len_next    = tag_len_reg;
        name_chars_next = name_chars_reg;
        name_len_next   = name_len_reg;
        kind_next       = kind_reg;
        prog_next       = prog_reg;
        started_next    = started_reg;

        res.valid = 1'b0;
        res.code  = ITEM_VALUE;
        res.kind  = kind_reg;
        res.data  = 8'd0;

        if (accept) begin
            if (req_type || (data_byte == CH_LT)) begin
                // end of document or a new tag drops whatever is open
                if ((phase_reg != PH_OUTSIDE) && started_reg) begin
                    res.valid = 1'b1;
                    res.code  = ITEM_ABANDON;
                end
                name_chars_next = '0;
                name_len_next   = '0;
                kind_next       = KIND_ANCHOR;
                prog_next       = '0;
                started_next    = 1'b0;
                if (req_type) begin
                    phase_next   = PH_OUTSIDE;
                    tag_len_next = '0;
                end else begin
                    phase_next   = PH_AFTER_LT;
                    tag_len_next = TAG_LEN_W'(1);
                end
            end else if (phase_reg != PH_OUTSIDE) begin
                if (tag_len_reg >= TAG_LEN_MAX) begin
                    // tag too long
                    if (started_reg) begin
                        res.valid = 1'b1;
                        res.code  = ITEM_ABANDON;
                    end
                    phase_next      = PH_OUTSIDE;
                    tag_len_next    = '0;
                    name_chars_next = '0;
                    name_len_next   = '0;
                    kind_next       = KIND_ANCHOR;
                    prog_next       = '0;
                    started_next    = 1'b0;
                end else if (data_byte == CH_GT) begin
                    if ((phase_reg == PH_SKIP_WS) || (phase_reg == PH_QUOTE_OPEN) ||
                        (phase_reg == PH_VALUE) || (phase_reg == PH_DONE)) begin
                        res.valid = 1'b1;
                        res.code  = ITEM_COMPLETE;
                    end
                    phase_next      = PH_OUTSIDE;
                    tag_len_next    = '0;
                    name_chars_next = '0;
                    name_len_next   = '0;
                    kind_next       = KIND_ANCHOR;
                    prog_next       = '0;
                    started_next    = 1'b0;
                end else begin
                    tag_len_next = tag_len_reg + TAG_LEN_W'(1);
                    unique case (phase_reg)
                        PH_AFTER_LT, PH_NAME:
                        begin
                            phase_next = PH_NAME;
                            if ((phase_reg == PH_AFTER_LT) && (data_byte == CH_SLASH)) begin
                                phase_next = PH_NAME;
                            end else if (is_letter(data_byte)) begin
                                name_chars_next = {name_chars_reg[31:0], to_upper(data_byte)};
                                if (name_len_reg < NAME_LEN_MAX) begin
                                    name_len_next = name_len_reg + 3'd1;
                                end
                            end else if (!nm.hit) begin
                                phase_next = PH_IGNORE;
                            end else begin
                                kind_next  = nm.kind;
                                prog_next  = kw_first.prog;
                                phase_next = kw_first.hit ? PH_SEEK_EQ : PH_KEYWORD;
                            end
                        end
                        PH_KEYWORD:
                        begin
                            prog_next = kw_cur.prog;
                            if (kw_cur.hit) begin
                                phase_next = PH_SEEK_EQ;
                            end
                        end
                        PH_SEEK_EQ:
                        begin
                            if (data_byte == CH_EQ) begin
                                phase_next = PH_SKIP_WS;
                            end
                        end
                        PH_SKIP_WS, PH_QUOTE_OPEN, PH_VALUE:
                        begin
                            if ((phase_reg == PH_SKIP_WS) && is_space(data_byte)) begin
                                phase_next = PH_SKIP_WS;
                            end else if ((phase_reg == PH_SKIP_WS) &&
                                         (data_byte == CH_QUOTE)) begin
                                phase_next = PH_QUOTE_OPEN;
                            end else if ((phase_reg == PH_QUOTE_OPEN) &&
                                         (data_byte == CH_QUOTE)) begin
                                // empty quoted value
                                phase_next = PH_IGNORE;
                            end else begin
                                phase_next   = PH_VALUE;
                                started_next = 1'b1;
                                if ((data_byte == CH_QUOTE) || (data_byte == CH_SPACE)) begin
                                    phase_next = PH_DONE;
                                end else if (!is_space(data_byte)) begin
                                    res.valid = 1'b1;
                                    res.code  = ITEM_VALUE;
                                    res.data  = data_byte;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_OUTSIDE;
            tag_len_reg    <= '0;
            name_chars_reg <= '0;
            name_len_reg   <= '0;
            kind_reg       <= KIND_ANCHOR;
            prog_reg       <= '0;
            started_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            tag_len_reg    <= tag_len_next;
            name_chars_reg <= name_chars_next;
            name_len_reg   <= name_len_next;
            kind_reg       <= kind_next;
            prog_reg       <= prog_next;
            started_reg    <= started_next;
        end
    end

endmodule

>>> rtl/html_link_attribute_extractor.sv
// ----------------------------------------------------------------------------
// html_link_attribute_extractor
// Streams href/src attribute values of A, AREA, BASE and FRAME tags out of
// an HTML byte stream, with commit and abandon markers per link.
// ----------------------------------------------------------------------------
//  channel   valid       stall       payload
//  request   req_valid   req_stall   req_type, data_byte
//  result    rsp_valid   rsp_stall   item_code, link_kind, value_byte
//
//  one request per clock while req_stall is low. the scanner state sits in
//  flops; any result is registered in the output register, or in the one
//  skid register while the output is full and stalled, and req_stall is high
//  only while the skid is full. reset returns the scanner to the outside-of-tag
//  state and empties both result registers.
// ----------------------------------------------------------------------------
module html_link_attribute_extractor
    import hlae_pkg::*;
#(
    parameter int MAX_TAG_BYTES = MAX_TAG_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [1:0] item_code,
    output logic [1:0] link_kind,
    output logic [7:0] value_byte
);

    logic      accept;
    logic      pop;
    hlae_res_t res;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    hlae_res_t out_res_reg, out_res_next;
    hlae_res_t skid_res_reg, skid_res_next;

    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign pop       = out_valid_reg && !rsp_stall;

    hlae_scan #(
        .MAX_TAG_BYTES (MAX_TAG_BYTES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .data_byte (data_byte),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res.valid) begin
            if (!out_valid_reg || pop) begin
                out_res_next   = res;
                out_valid_next = 1'b1;
            end else begin
                skid_res_next   = res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign item_code  = out_res_reg.code;
    assign link_kind  = out_res_reg.kind;
    assign value_byte = out_res_reg.data;

endmodule
